// ----- design/tts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_pkg: shared types and constants of the two-track tone sequencer
// Item and result beats, command codes, track and register indexes,
// sequencer states.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int NOTE_DEPTH_DEF = 256;

  localparam logic [9:0] US_PER_MS = 10'd1000;
  localparam logic [8:0] MAX_SONG  = 9'd256;

  localparam logic TRK_BGM = 1'b0;
  localparam logic TRK_SFX = 1'b1;

  localparam logic CFG_BGM_MUTED = 1'b0;
  localparam logic CFG_SFX_MUTED = 1'b1;

  typedef enum logic [2:0] {
    ACT_LOAD     = 3'd0,
    ACT_PLAY_BGM = 3'd1,
    ACT_PLAY_SFX = 3'd2,
    ACT_STOP     = 3'd3,
    ACT_TICK     = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PLAY_FRQ,
    S_TRK_RD,
    S_TRK_MUL,
    S_TRK_CMP,
    S_TRK_FRQ,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [47:0] now_us;
    logic [7:0]  entry_addr;
    logic [15:0] note_freq;
    logic [15:0] note_ms;
    logic [7:0]  song_base;
    logic [8:0]  song_length;
    logic        loop_song;
  } item_t;

  typedef struct packed {
    logic [15:0] tone_freq;
    logic        tone_update;
    logic        sfx_active;
    logic        bgm_active;
  } result_t;

  typedef struct packed {
    logic [15:0] freq;
    logic [15:0] dur;
  } note_t;

  typedef struct packed {
    logic take;
    logic emit;
  } tts_ctl_t;

endpackage

// ----- design/two_track_tone_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_track_tone_sequencer: top level
// An active tick runs per track: note store read, duration multiply,
//   end-time compare, and a second note store read when the driving track
//   changes note.
// The core takes one beat at a time; a tick holds the core and the single
//   note store read port until its result is emitted.
// Reset clears both tracks, the tone, the mutes and pauses ticking; the note
//   store is not cleared.
// ----------------------------------------------------------------------------
module two_track_tone_sequencer
  import tts_pkg::*;
#(
  parameter int NOTE_DEPTH = NOTE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result,
  input  logic    cfg_we,
  input  logic    cfg_index,
  input  logic    cfg_data
);

  item_t    item_buf;
  logic     buf_full;
  logic     out_ready;
  tts_ctl_t ctl;
  result_t  core_res;

  assign item_stall = buf_full;
  assign out_ready  = !result_valid || !result_stall;

  // hold one input beat
  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) item_buf <= item;
    if (rst) begin
      buf_full <= 1'b0;
    end else if (item_valid && !item_stall) begin
      buf_full <= 1'b1;
    end else if (ctl.take) begin
      buf_full <= 1'b0;
    end
  end

  tts_core #(
    .NOTE_DEPTH(NOTE_DEPTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .item        (item_buf),
    .item_present(buf_full),
    .out_ready   (out_ready),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .ctl         (ctl),
    .res         (core_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (ctl.emit) result <= core_res;
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> (!result_valid || !result_stall))
    else $error("result emitted into a full output register");

  a_take_needs_beat: assert property (@(posedge clk) disable iff (rst)
    ctl.take |-> buf_full)
    else $error("core took an item from an empty buffer");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(ctl.emit))
    else $error("result valid rose without an emit");

endmodule

// ----- design/tts_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_core: note store and track sequencer
// Holds the note store memory and both track contexts; runs one item at a
// time, and a tick goes through read, multiply, compare and tone-read steps per track.
// ----------------------------------------------------------------------------
module tts_core
  import tts_pkg::*;
#(
  parameter int NOTE_DEPTH = NOTE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  item_t    item,
  input  logic     item_present,
  input  logic     out_ready,
  input  logic     cfg_we,
  input  logic     cfg_index,
  input  logic     cfg_data,
  output tts_ctl_t ctl,
  output result_t  res
);

  // NOTE_DEPTH must be a power of two; the block does not enforce it
  localparam int AW = $clog2(NOTE_DEPTH);
  localparam int SW = (AW > 9) ? AW : 9;

  function automatic logic [AW-1:0] note_addr(input logic [7:0] b, input logic [8:0] i);
    logic [SW-1:0] s;
    s = SW'(b) + SW'(i);
    return s[AW-1:0];
  endfunction

  note_t mem [NOTE_DEPTH];
  note_t rd_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic wr_en;
  note_t wr_data;

  state_t state, state_next;
  logic trk, trk_next;
  logic sfx_on, sfx_on_next;
  logic [47:0] now_r, now_next;
  logic [25:0] prod, prod_next;
  logic [1:0] present, present_next;
  logic [7:0] base [2];
  logic [7:0] base_next [2];
  logic [8:0] length [2];
  logic [8:0] length_next [2];
  logic [1:0] loopf, loopf_next;
  logic [8:0] index [2];
  logic [8:0] index_next [2];
  logic [47:0] start [2];
  logic [47:0] start_next [2];
  logic [15:0] cur_freq, cur_freq_next;
  logic upd, upd_next;
  logic ticking, ticking_next;
  logic bgm_muted, sfx_muted;

  logic go, last_trk, skip_trk, note_done, next_ok, drives, tick_run, play_ok;
  logic [48:0] end_us;
  logic [8:0] idx_inc, idx_wrap, song_len;
  logic tone_req, stop_req, done_trk, done_on, play_trk;
  state_t dispatch_state;

  assign go       = item_present && ((state == S_IDLE) || ((state == S_EMIT) && out_ready));
  assign last_trk = (trk == TRK_BGM);
  assign skip_trk = !present[trk] || (index[trk] >= length[trk]);
  assign end_us   = {1'b0, start[trk]} + 49'(prod);
  assign note_done = ({1'b0, now_r} >= end_us);
  assign idx_inc  = index[trk] + 9'd1;
  assign idx_wrap = (loopf[trk] && (idx_inc == length[trk])) ? 9'd0 : idx_inc;
  assign next_ok  = (idx_wrap < length[trk]);
  assign drives   = (trk == TRK_SFX) || !sfx_on;
  assign tick_run = ticking && !(bgm_muted && sfx_muted);
  assign play_ok  = (item.song_length != 9'd0);
  assign song_len = (item.song_length > MAX_SONG) ? MAX_SONG : item.song_length;
  assign play_trk = (item.action == ACT_PLAY_SFX) ? TRK_SFX : TRK_BGM;

  always_comb begin
    unique case (item.action)
      ACT_PLAY_BGM, ACT_PLAY_SFX: dispatch_state = play_ok ? S_PLAY_FRQ : S_EMIT;
      ACT_TICK:                   dispatch_state = tick_run ? S_TRK_RD : S_EMIT;
      default:                    dispatch_state = S_EMIT;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (go) state_next = dispatch_state;
      S_EMIT: begin
        if (out_ready) state_next = item_present ? dispatch_state : S_IDLE;
      end
      S_PLAY_FRQ: state_next = S_EMIT;
      S_TRK_RD: begin
        if (skip_trk) state_next = last_trk ? S_EMIT : S_TRK_RD;
        else state_next = S_TRK_MUL;
      end
      S_TRK_MUL:  state_next = S_TRK_CMP;
      S_TRK_CMP: begin
        if (note_done && next_ok && drives) state_next = S_TRK_FRQ;
        else state_next = last_trk ? S_EMIT : S_TRK_RD;
      end
      S_TRK_FRQ:  state_next = last_trk ? S_EMIT : S_TRK_RD;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    trk_next      = trk;
    sfx_on_next   = sfx_on;
    now_next      = now_r;
    prod_next     = prod;
    present_next  = present;
    base_next     = base;
    length_next   = length;
    loopf_next    = loopf;
    index_next    = index;
    start_next    = start;
    ticking_next  = ticking;
    cur_freq_next = cur_freq;
    upd_next      = go ? 1'b0 : upd;
    wr_en         = 1'b0;
    wr_addr       = note_addr(item.entry_addr, 9'd0);
    wr_data       = '{freq: item.note_freq, dur: item.note_ms};
    rd_addr       = note_addr(base[trk], index[trk]);
    tone_req      = 1'b0;
    stop_req      = 1'b0;
    done_trk      = 1'b0;
    done_on       = 1'b0;

    if (go) begin
      trk_next = TRK_SFX;
      now_next = item.now_us;
      unique case (item.action)
        ACT_LOAD: wr_en = 1'b1;
        ACT_PLAY_BGM, ACT_PLAY_SFX: begin
          if (play_ok) begin
            trk_next               = play_trk;
            present_next[play_trk] = 1'b1;
            base_next[play_trk]    = item.song_base;
            length_next[play_trk]  = song_len;
            loopf_next[play_trk]   = item.loop_song;
            index_next[play_trk]   = 9'd0;
            start_next[play_trk]   = item.now_us;
            ticking_next           = 1'b1;
            rd_addr                = note_addr(item.song_base, 9'd0);
          end
        end
        ACT_STOP: begin
          ticking_next  = 1'b0;
          stop_req      = 1'b1;
          present_next  = 2'b00;
          index_next[0] = 9'd0;
          index_next[1] = 9'd0;
          start_next[0] = 48'd0;
          start_next[1] = 48'd0;
        end
        default: ;
      endcase
    end else begin
      case (state)
        S_PLAY_FRQ: tone_req = (trk == TRK_SFX) || !present[TRK_SFX];
        S_TRK_RD: begin
          if (skip_trk) done_trk = 1'b1;
        end
        S_TRK_MUL: prod_next = 26'(rd_data.dur * US_PER_MS);
        S_TRK_CMP: begin
          if (note_done) begin
            start_next[trk] = now_r;
            if (next_ok) begin
              index_next[trk] = idx_wrap;
              rd_addr         = note_addr(base[trk], idx_wrap);
              if (!drives) begin
                done_trk = 1'b1;
                done_on  = 1'b1;
              end
            end else begin
              stop_req          = drives;
              present_next[trk] = 1'b0;
              index_next[trk]   = 9'd0;
              start_next[trk]   = 48'd0;
              done_trk          = 1'b1;
            end
          end else begin
            done_trk = 1'b1;
            done_on  = 1'b1;
          end
        end
        S_TRK_FRQ: begin
          tone_req = 1'b1;
          done_trk = 1'b1;
          done_on  = 1'b1;
        end
        default: ;
      endcase
    end

    if (stop_req || (tone_req && (rd_data.freq == 16'd0))) begin
      cur_freq_next = 16'd0;
      upd_next      = 1'b1;
    end else if (tone_req && (rd_data.freq != cur_freq)) begin
      cur_freq_next = rd_data.freq;
      upd_next      = 1'b1;
    end

    // hand over from the effect track to the background track
    if (done_trk && (trk == TRK_SFX)) begin
      sfx_on_next = done_on;
      trk_next    = TRK_BGM;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    now_r   <= now_next;
    prod    <= prod_next;
    base    <= base_next;
    loopf   <= loopf_next;
    trk     <= trk_next;
    sfx_on  <= sfx_on_next;
    if (rst) begin
      state     <= S_IDLE;
      present   <= 2'b00;
      length[0] <= 9'd0;
      length[1] <= 9'd0;
      index[0]  <= 9'd0;
      index[1]  <= 9'd0;
      start[0]  <= 48'd0;
      start[1]  <= 48'd0;
      cur_freq  <= 16'd0;
      upd       <= 1'b0;
      ticking   <= 1'b0;
      bgm_muted <= 1'b0;
      sfx_muted <= 1'b0;
    end else begin
      state    <= state_next;
      present  <= present_next;
      length   <= length_next;
      index    <= index_next;
      start    <= start_next;
      cur_freq <= cur_freq_next;
      upd      <= upd_next;
      ticking  <= ticking_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BGM_MUTED: bgm_muted <= cfg_data;
          CFG_SFX_MUTED: sfx_muted <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign ctl.take = go;
  assign ctl.emit = (state == S_EMIT) && out_ready;

  assign res = '{tone_freq:   cur_freq,
                 tone_update: upd,
                 sfx_active:  present[TRK_SFX],
                 bgm_active:  present[TRK_BGM]};

endmodule
